// ----- rtl/alfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfr_pkg
// Shared types and constants of the additive lagged-fibonacci generator.
// ----------------------------------------------------------------------------
package alfr_pkg;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_B32   = 2'd1;
    localparam logic [1:0] MODE_B64   = 2'd2;
    localparam logic [1:0] MODE_SEED  = 2'd3;

    localparam logic [31:0] PM_MODULUS = 32'd2147483647;
    localparam logic [14:0] PM_MULT    = 15'd16807;
    localparam logic [16:0] PM_QUOT    = 17'd127773;
    localparam logic [11:0] PM_REM     = 12'd2836;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] bound;
    } alfr_in_t;

    typedef struct packed {
        logic [63:0] value;
        logic        bad_bound;
    } alfr_out_t;

    // datapath commands
    typedef struct packed {
        logic seed_start;   // load word 0, reset taps
        logic seed_step;    // one step of a park-miller word
        logic draw;         // one table draw
        logic draw_hi;      // draw goes to the upper word
        logic clr_acc;      // clear draw accumulator
        logic div_start;    // start modulo
        logic div_step;     // one remainder bit
        logic div_w64;      // modulo over 64 bits
    } alfr_cmd_t;

    typedef struct packed {
        logic seed_last;    // last table word being written
        logic div_last;     // last remainder bit
    } alfr_sts_t;

endpackage

// ----- rtl/alfr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfr_datapath
// Lag table memory, park-miller seeding step, draw adder and a
// restoring bit-serial modulo unit.
// ----------------------------------------------------------------------------
module alfr_datapath #(
    parameter int TABLE_SIZE     = 31,
    parameter int LAG_SEPARATION = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  alfr_pkg::alfr_cmd_t cmd,
    output alfr_pkg::alfr_sts_t sts,
    input  logic [31:0]       seed,
    input  logic [63:0]       bound,
    output logic [63:0]       result
);
    import alfr_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] FRONT0 =
        (LAG_SEPARATION < TABLE_SIZE) ? IW'(LAG_SEPARATION) : '0;
    // reciprocal of PM_QUOT scaled by 2^48
    localparam logic [31:0] PM_RECIP = 32'((64'd1 << 48) / 64'(PM_QUOT));

    // table held in flip-flops, each read at the tap indices
    logic [31:0]   tbl_reg [TABLE_SIZE];
    logic [IW-1:0] front_reg, rear_reg;
    logic [IW-1:0] front_next, rear_next;

    // seeding state: current x (signed), write index, pipeline stage
    logic signed [31:0] x_reg;
    logic [IW-1:0]      widx_reg;
    logic [1:0]         pm_ph_reg;
    logic [15:0]        qest_reg;
    logic signed [47:0] prod_a_reg, prod_b_reg;
    logic signed [31:0] q_reg, m_reg;

    logic [63:0] acc_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  bit_reg;

    logic [31:0] w_sum;
    assign w_sum = tbl_reg[front_reg] + tbl_reg[rear_reg];

    // cyclic tap advance
    always_comb
    begin
        front_next = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
        rear_next  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;
    end

    // truncating division by PM_QUOT: reciprocal estimate, then one correction
    logic [31:0] x_mag;
    logic [63:0] qprod;
    logic [31:0] qd;
    logic [31:0] rm_raw;
    logic [31:0] qm;
    logic [31:0] rm;
    logic signed [48:0] t_sum;
    assign x_mag = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
    always_comb
    begin
        qprod = 64'(x_mag) * 64'(PM_RECIP);
        qd = 32'(qest_reg) * 32'(PM_QUOT);
        rm_raw = x_mag - qd;
        if (rm_raw >= 32'(PM_QUOT))
        begin
            qm = 32'(qest_reg) + 32'd1;
            rm = rm_raw - 32'(PM_QUOT);
        end
        else
        begin
            qm = 32'(qest_reg);
            rm = rm_raw;
        end
        t_sum = 49'(prod_a_reg) - 49'(prod_b_reg);
        if (t_sum < 0)
            t_sum = t_sum + 49'(PM_MODULUS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_ph_reg <= '0;
            front_reg <= FRONT0;
            rear_reg  <= '0;
        end
        else
        begin
            if (cmd.seed_start)
            begin
                pm_ph_reg <= '0;
                front_reg <= FRONT0;
                rear_reg  <= '0;
            end
            else if (cmd.seed_step)
            begin
                pm_ph_reg <= pm_ph_reg + 2'd1;
            end
            else if (cmd.draw)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_start)
        begin
            tbl_reg[0] <= seed;
            x_reg      <= seed;
            widx_reg   <= IW'(1);
        end
        else if (cmd.seed_step)
        begin
            case (pm_ph_reg)
                2'd0:
                begin
                    qest_reg <= qprod[63:48];
                end
                2'd1:
                begin
                    q_reg <= x_reg[31] ? -$signed(qm) : $signed(qm);
                    m_reg <= x_reg[31] ? -$signed(rm) : $signed(rm);
                end
                2'd2:
                begin
                    prod_a_reg <= 48'(m_reg) * 48'(PM_MULT);
                    prod_b_reg <= 48'(q_reg) * 48'(PM_REM);
                end
                default:
                begin
                    x_reg <= t_sum[31:0];
                    tbl_reg[widx_reg] <= t_sum[31:0];
                    widx_reg <= widx_reg + 1'b1;
                end
            endcase
        end
        else if (cmd.draw)
        begin
            tbl_reg[front_reg] <= w_sum;
        end
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (cmd.draw)
        begin
            if (cmd.draw_hi)
                acc_reg[63:32] <= {1'b0, w_sum[31:1]};
            else
                acc_reg[31:0] <= {1'b0, w_sum[31:1]};
        end
        // restoring remainder, one bit per cycle, msb first
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= acc_reg;
            bit_reg <= cmd.div_w64 ? 7'd63 : 7'd31;
        end
        else if (cmd.div_step)
        begin
            logic [64:0] trial;
            logic [63:0] dv;
            trial = {rem_reg, cmd.div_w64 ? quo_reg[63] : quo_reg[31]};
            dv = cmd.div_w64 ? bound : {32'd0, bound[31:0]};
            if (trial >= {1'b0, dv})
                trial = trial - {1'b0, dv};
            rem_reg <= trial[63:0];
            quo_reg <= {quo_reg[62:0], 1'b0};
            bit_reg <= bit_reg - 7'd1;
        end
    end

    assign sts.seed_last = (widx_reg == LAST_IDX) && (pm_ph_reg == 2'd3);
    assign sts.div_last  = (bit_reg == 7'd0);
    assign result = cmd.clr_acc ? acc_reg : rem_reg;
endmodule

// ----- rtl/alfr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfr_ctrl
// Sequencer: reseed fill, warm-up draws, draws and modulo per request.
// ----------------------------------------------------------------------------
module alfr_ctrl #(
    parameter int TABLE_SIZE    = 31,
    parameter int WARMUP_ROUNDS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  alfr_pkg::alfr_in_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output alfr_pkg::alfr_out_t out_data,
    output alfr_pkg::alfr_cmd_t cmd,
    input  alfr_pkg::alfr_sts_t sts,
    input  logic [63:0]       result
);
    import alfr_pkg::*;

    localparam int WARM = WARMUP_ROUNDS * TABLE_SIZE;
    localparam int WW = $clog2(WARM + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_WARM = 3'd2;
    localparam logic [2:0] S_DRAW = 3'd3;
    localparam logic [2:0] S_DRAW2 = 3'd4;
    localparam logic [2:0] S_DIVI = 3'd5;
    localparam logic [2:0] S_DIV = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [WW-1:0] cnt_reg, cnt_next;
    logic [1:0]    mode_reg, mode_next;
    logic          rst_seed_reg, rst_seed_next;
    logic          oval_reg, oval_next;
    alfr_out_t     odata_reg, odata_next;
    logic          zero_b;
    logic          accept;

    assign in_stall = (state_reg != S_IDLE) || oval_reg || rst_seed_reg;
    assign accept   = in_valid && !in_stall;
    assign zero_b = (in_data.mode == MODE_B32) ? (in_data.bound[31:0] == 32'd0)
                                               : (in_data.bound == 64'd0);

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        rst_seed_next = rst_seed_reg;
        oval_next = oval_reg && out_stall;
        odata_next = odata_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (rst_seed_reg)
                begin
                    cmd.seed_start = 1'b1;
                    state_next = S_SEED;
                end
                else if (accept)
                begin
                    mode_next = in_data.mode;
                    cmd.clr_acc = 1'b1;
                    case (in_data.mode)
                        MODE_SEED:
                        begin
                            cmd.seed_start = 1'b1;
                            state_next = S_SEED;
                        end
                        MODE_RAW: state_next = S_DRAW;
                        default:
                        begin
                            if (zero_b)
                            begin
                                oval_next = 1'b1;
                                odata_next.value = '0;
                                odata_next.bad_bound = 1'b1;
                            end
                            else
                                state_next = S_DRAW;
                        end
                    endcase
                end
            end
            S_SEED:
            begin
                cmd.seed_step = 1'b1;
                if (sts.seed_last)
                begin
                    state_next = S_WARM;
                    cnt_next = WW'(WARM);
                end
            end
            S_WARM:
            begin
                cmd.draw = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == WW'(1))
                begin
                    state_next = S_IDLE;
                    if (rst_seed_reg)
                        rst_seed_next = 1'b0;
                    else
                    begin
                        oval_next = 1'b1;
                        odata_next = '0;
                    end
                end
            end
            S_DRAW:
            begin
                cmd.draw = 1'b1;
                state_next = (mode_reg == MODE_B64) ? S_DRAW2 : S_DIVI;
            end
            S_DRAW2:
            begin
                cmd.draw = 1'b1;
                cmd.draw_hi = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                if (mode_reg == MODE_RAW)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_w64 = (mode_reg == MODE_B64);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_w64 = (mode_reg == MODE_B64);
                if (sts.div_last)
                    state_next = S_DONE;
            end
            default:
            begin
                cmd.clr_acc = (mode_reg == MODE_RAW);
                oval_next = 1'b1;
                odata_next.value = result;
                odata_next.bad_bound = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            mode_reg <= MODE_RAW;
            rst_seed_reg <= 1'b1;
            oval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            mode_reg <= mode_next;
            rst_seed_reg <= rst_seed_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign out_valid = oval_reg;
    assign out_data = odata_reg;
endmodule

// ----- rtl/additive_lagged_fibonacci_rng_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_rng_unit
// Additive lagged-fibonacci random generator with bounded draws and reseed.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | beat
// in      | in  | in_valid/in_stall  | mode, bound
// out     | out | out_valid/out_stall| value, bad_bound
// cfg     | in  | cfg_valid/cfg_ready| seed word
//
// accept to result valid: a raw draw passes the draw, divide-init and done states;
// a bounded draw adds a remainder pass of 32 or 64 bits, one bit per cycle, and
// bounded 64-bit draws twice. zero bound: result set straight at accept. reseed:
// park-miller fill of TABLE_SIZE-1 words, then WARMUP_ROUNDS*TABLE_SIZE draws. after reset
// the same seeding pass runs with seed 1 before the first beat is taken.
// one beat in flight at a time; a stalled result holds the block.
// ----------------------------------------------------------------------------
module additive_lagged_fibonacci_rng_unit #(
    parameter int TABLE_SIZE     = 31,
    parameter int LAG_SEPARATION = 3,
    parameter int WARMUP_ROUNDS  = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  alfr_pkg::alfr_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output alfr_pkg::alfr_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import alfr_pkg::*;

    alfr_cmd_t   cmd;
    alfr_sts_t   sts;
    logic [63:0] result;
    logic [31:0] seed_reg;
    logic [63:0] bound_reg;

    // seed register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= 32'd1;
        else if (cfg_valid)
            seed_reg <= cfg_data;
    end

    // bound held for the whole request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bound_reg <= 64'd0;
        else if (in_valid && !in_stall)
            bound_reg <= in_data.bound;
    end

    alfr_ctrl #(
        .TABLE_SIZE(TABLE_SIZE),
        .WARMUP_ROUNDS(WARMUP_ROUNDS)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cmd(cmd), .sts(sts), .result(result)
    );

    alfr_datapath #(
        .TABLE_SIZE(TABLE_SIZE),
        .LAG_SEPARATION(LAG_SEPARATION)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .seed(seed_reg), .bound(bound_reg), .result(result)
    );

`ifndef NO_ASSERTIONS
    // a draw and a seeding step never coincide
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.draw && cmd.seed_step))
        else $error("draw during seeding");
    // a zero-bound result flags bad_bound with zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_bound |-> out_data.value == 64'd0)
        else $error("bad bound with nonzero value");
    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif
endmodule

// ----- sim/additive_lagged_fibonacci_rng_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_rng_unit_test
// Checks raw, bounded and reseed requests of the lagged-fibonacci generator
// against a behavioral copy of the lag table, under random idling and stall.
// ----------------------------------------------------------------------------
module additive_lagged_fibonacci_rng_unit_test;
    import alfr_pkg::*;

    localparam int NWORDS    = 31;
    localparam int SEP       = 3;
    localparam int WARMUP    = 10;
    localparam int WDOG_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    alfr_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    alfr_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // behavioral generator state
    logic [31:0] lag_words [NWORDS];
    int unsigned front_tap;
    int unsigned rear_tap;
    logic [31:0] seed_reg;

    alfr_out_t   expected_beats [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          quiet_cycles;

    additive_lagged_fibonacci_rng_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one table draw, 31-bit result
    function automatic logic [30:0] table_draw();
        logic [31:0] w;
        w = lag_words[front_tap] + lag_words[rear_tap];
        lag_words[front_tap] = w;
        front_tap = (front_tap + 1) % NWORDS;
        rear_tap  = (rear_tap + 1) % NWORDS;
        return w[31:1];
    endfunction

    // park-miller fill plus warm-up
    function automatic void table_reseed(logic [31:0] seed);
        longint x;
        longint q;
        longint m;
        longint t;
        logic [30:0] junk;
        x = longint'($signed(seed));
        lag_words[0] = seed;
        for (int i = 1; i < NWORDS; i++)
        begin
            q = x / 127773;
            m = x % 127773;
            t = 16807 * m - 2836 * q;
            if (t < 0)
                t += 2147483647;
            x = t;
            lag_words[i] = t[31:0];
        end
        front_tap = SEP;
        rear_tap  = 0;
        for (int i = 0; i < WARMUP * NWORDS; i++)
            junk = table_draw();
    endfunction

    function automatic alfr_out_t predict_beat(alfr_in_t req);
        alfr_out_t r;
        logic [63:0] lo;
        logic [63:0] hi;
        r = '0;
        case (req.mode)
            MODE_RAW: r.value = 64'(table_draw());
            MODE_B32:
                if (req.bound[31:0] == 32'd0)
                    r.bad_bound = 1'b1;
                else
                    r.value = 64'(32'(table_draw()) % req.bound[31:0]);
            MODE_B64:
                if (req.bound == 64'd0)
                    r.bad_bound = 1'b1;
                else
                begin
                    lo = 64'(table_draw());
                    hi = 64'(table_draw());
                    r.value = (lo | (hi << 32)) % req.bound;
                end
            default: table_reseed(seed_reg);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // send one request beat with random idling
    task automatic send_request(logic [1:0] mode, logic [63:0] bound);
        alfr_in_t req;
        req.mode  = mode;
        req.bound = bound;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_beats.push_back(predict_beat(req));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] seed);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        seed_reg = seed;
    endtask

    function automatic logic [63:0] rand_bound();
        case ($urandom_range(5))
            0: return 64'($urandom_range(1, 20));
            1: return {32'd0, $urandom()};
            2: return {$urandom(), $urandom()};
            3: return 64'd1 << $urandom_range(63);
            4: return {32'(0), 32'hffff_ffff};
            default: return {$urandom_range(7), $urandom()};
        endcase
    endfunction

    task automatic random_requests(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(MODE_RAW, rand_bound());
            else if (pick < 60)
                send_request(MODE_B32, (pick == 31) ? 64'hffff_ffff_0000_0000 : rand_bound());
            else if (pick < 93)
                send_request(MODE_B64, (pick == 61) ? 64'd0 : rand_bound());
            else
                send_request(MODE_SEED, rand_bound());
        end
    endtask

    // directed extremes and special cases
    task automatic test_directed();
        send_request(MODE_RAW, 64'hffff_ffff_ffff_ffff);
        send_request(MODE_RAW, 64'd0);
        send_request(MODE_B32, 64'd0);
        send_request(MODE_B32, 64'hffff_ffff_0000_0000);
        send_request(MODE_B32, 64'd1);
        send_request(MODE_B32, 64'hffff_ffff);
        send_request(MODE_B32, 64'h8000_0000);
        send_request(MODE_B64, 64'd0);
        send_request(MODE_B64, 64'd1);
        send_request(MODE_B64, 64'hffff_ffff_ffff_ffff);
        send_request(MODE_B64, 64'h8000_0000_0000_0000);
        send_request(MODE_B64, 64'h0000_0001_0000_0000);
        send_request(MODE_SEED, 64'd0);
        send_request(MODE_RAW, 64'd0);
        write_seed(32'd0);
        send_request(MODE_SEED, 64'hffff_ffff_ffff_ffff);
        send_request(MODE_RAW, 64'd0);
        send_request(MODE_B64, 64'd7);
        write_seed(32'hffff_ffff);
        send_request(MODE_SEED, 64'd0);
        send_request(MODE_RAW, 64'd0);
        write_seed(32'h8000_0000);
        send_request(MODE_SEED, 64'd0);
        send_request(MODE_B32, 64'd3);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;
        write_seed($urandom());
        random_requests(200);
        send_idle_pct = 74; recv_stall_pct = 0;
        write_seed(32'h7fff_ffff);
        random_requests(200);
        send_idle_pct = 0;  recv_stall_pct = 74;
        write_seed($urandom());
        random_requests(200);
        send_idle_pct = 38; recv_stall_pct = 38;
        write_seed(32'd1);
        random_requests(200);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 1'b1;
        random_requests(50);
        hold_off = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        alfr_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", out_data.value, 64'd0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_data.value !== want.value)
                    report_mismatch("value", out_data.value, want.value);
                if (out_data.bad_bound !== want.bad_bound)
                    report_mismatch("bad_bound", 64'(out_data.bad_bound), 64'(want.bad_bound));
            end
        end
    end

    // receiver stall, with a long counted hold-off on request
    initial
    begin
        int hold_cycles;
        hold_cycles = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off && hold_cycles < 3000)
            begin
                hold_cycles++;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        seed_reg = 32'd1;
        table_reseed(32'd1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (500) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
